[src/rv32i_instruction_decoder_assert.svh]
// Assertion macros shared by the RV32I decoder RTL.
// Each macro checks one implication, sampled on the rising clock edge
// and disabled while the active-low reset is asserted.
`ifndef RV32I_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVDEC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvdec assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define RVDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvdec assertion failed (next cycle)");

`endif

[src/rvdec_pkg.sv]
// Package for the RV32I decoder: major opcodes, funct7 values, special CSR values,
// the operation class enum and the decode result struct.
// No dependencies.
`default_nettype none

package rvdec_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [11:0] CSR_IMM_ECALL  = 12'h000;
    localparam logic [11:0] CSR_IMM_EBREAK = 12'h001;
    localparam logic [11:0] CSR_MRET       = 12'h302;

    typedef enum logic [5:0] {
        CLS_NONE,
        CLS_ADD, CLS_XOR, CLS_OR, CLS_AND, CLS_SLL, CLS_SRL, CLS_SLT, CLS_SLTU,
        CLS_SUB, CLS_SRA,
        CLS_ADDI, CLS_XORI, CLS_ORI, CLS_ANDI, CLS_SLTI, CLS_SLTIU,
        CLS_SLLI, CLS_SRLI, CLS_SRAI,
        CLS_LW, CLS_LB, CLS_LBU, CLS_LH, CLS_LHU,
        CLS_SW, CLS_SB, CLS_SH,
        CLS_BEQ, CLS_BNE, CLS_BLT, CLS_BGE, CLS_BLTU, CLS_BGEU,
        CLS_JALR, CLS_JAL, CLS_LUI, CLS_AUIPC, CLS_FENCE,
        CLS_ECALL, CLS_EBREAK, CLS_MRET,
        CLS_CSRRW, CLS_CSRRS, CLS_CSRRC, CLS_CSRRWI, CLS_CSRRSI, CLS_CSRRCI
    } op_class_t;

    typedef struct packed {
        logic [WORD_W-1:0] immediate;
        op_class_t         op_class;
    } dec_result_t;

endpackage

`default_nettype wire

[src/rvdec_decode.sv]
// Combinational RV32I decode: immediate selection and operation class.
// Depends on rvdec_pkg.
`default_nettype none

module rvdec_decode
    import rvdec_pkg::*;
(
    input  wire logic [WORD_W-1:0] instr_word,
    output dec_result_t            result
);

    logic [6:0]        opcode;
    logic [4:0]        rd;
    logic [2:0]        f3;
    logic [4:0]        rs1;
    logic [6:0]        f7;
    logic [11:0]       csr;
    logic              sys_base;
    logic [WORD_W-1:0] imm_val;
    op_class_t         class_val;

    assign opcode = instr_word[6:0];
    assign rd     = instr_word[11:7];
    assign f3     = instr_word[14:12];
    assign rs1    = instr_word[19:15];
    assign f7     = instr_word[31:25];
    assign csr    = instr_word[31:20];

    // ECALL, EBREAK and MRET all require rd and rs1 to be zero.
    assign sys_base = (rd == 5'd0) && (rs1 == 5'd0);

    assign result = {imm_val, class_val};

    always_comb
    begin
        unique case (opcode)
            OPC_LOAD, OPC_OP_IMM, OPC_JALR, OPC_SYSTEM:
                imm_val = {{20{instr_word[31]}}, instr_word[31:20]};
            OPC_STORE:
                imm_val = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
            OPC_BRANCH:
                imm_val = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                           instr_word[30:25], instr_word[11:8], 1'b0};
            OPC_JAL:
                imm_val = {{11{instr_word[31]}}, instr_word[31],
                           instr_word[19:12], instr_word[20],
                           instr_word[30:21], 1'b0};
            OPC_AUIPC, OPC_LUI:
                imm_val = {instr_word[31:12], 12'h000};
            default:
                imm_val = '0;
        endcase
    end

    always_comb
    begin
        class_val = CLS_NONE;
        unique case (opcode)
            OPC_OP:
            begin
                if (f7 == F7_BASE)
                begin
                    unique case (f3)
                        3'd0:    class_val = CLS_ADD;
                        3'd1:    class_val = CLS_SLL;
                        3'd2:    class_val = CLS_SLT;
                        3'd3:    class_val = CLS_SLTU;
                        3'd4:    class_val = CLS_XOR;
                        3'd5:    class_val = CLS_SRL;
                        3'd6:    class_val = CLS_OR;
                        default: class_val = CLS_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                    class_val = CLS_SUB;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    class_val = CLS_SRA;
            end
            OPC_OP_IMM:
            begin
                unique case (f3)
                    3'd0: class_val = CLS_ADDI;
                    3'd1: class_val = (f7 == F7_BASE) ? CLS_SLLI : CLS_NONE;
                    3'd2: class_val = CLS_SLTI;
                    3'd3: class_val = CLS_SLTIU;
                    3'd4: class_val = CLS_XORI;
                    3'd5:
                    begin
                        if (f7 == F7_BASE)
                            class_val = CLS_SRLI;
                        else if (f7 == F7_ALT)
                            class_val = CLS_SRAI;
                    end
                    3'd6:    class_val = CLS_ORI;
                    default: class_val = CLS_ANDI;
                endcase
            end
            OPC_LOAD:
            begin
                unique case (f3)
                    3'd0:    class_val = CLS_LB;
                    3'd1:    class_val = CLS_LH;
                    3'd2:    class_val = CLS_LW;
                    3'd4:    class_val = CLS_LBU;
                    3'd5:    class_val = CLS_LHU;
                    default: class_val = CLS_NONE;
                endcase
            end
            OPC_STORE:
            begin
                unique case (f3)
                    3'd0:    class_val = CLS_SB;
                    3'd1:    class_val = CLS_SH;
                    3'd2:    class_val = CLS_SW;
                    default: class_val = CLS_NONE;
                endcase
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    3'd0:    class_val = CLS_BEQ;
                    3'd1:    class_val = CLS_BNE;
                    3'd4:    class_val = CLS_BLT;
                    3'd5:    class_val = CLS_BGE;
                    3'd6:    class_val = CLS_BLTU;
                    3'd7:    class_val = CLS_BGEU;
                    default: class_val = CLS_NONE;
                endcase
            end
            OPC_JALR:  class_val = (f3 == 3'd0) ? CLS_JALR : CLS_NONE;
            OPC_JAL:   class_val = CLS_JAL;
            OPC_LUI:   class_val = CLS_LUI;
            OPC_AUIPC: class_val = CLS_AUIPC;
            OPC_FENCE: class_val = (f3 == 3'd0) ? CLS_FENCE : CLS_NONE;
            OPC_SYSTEM:
            begin
                unique case (f3)
                    3'd0:
                    begin
                        // The I-immediate equals the sign-extended CSR field, so
                        // comparing the CSR field against 0 and 1 is equivalent.
                        if (sys_base && csr == CSR_IMM_ECALL)
                            class_val = CLS_ECALL;
                        else if (sys_base && csr == CSR_IMM_EBREAK)
                            class_val = CLS_EBREAK;
                        else if (sys_base && csr == CSR_MRET)
                            class_val = CLS_MRET;
                    end
                    3'd1:    class_val = CLS_CSRRW;
                    3'd2:    class_val = CLS_CSRRS;
                    3'd3:    class_val = CLS_CSRRC;
                    3'd5:    class_val = CLS_CSRRWI;
                    3'd6:    class_val = CLS_CSRRSI;
                    3'd7:    class_val = CLS_CSRRCI;
                    default: class_val = CLS_NONE;
                endcase
            end
            default: class_val = CLS_NONE;
        endcase
    end

endmodule

`default_nettype wire

[src/rv32i_instruction_decoder.sv]
// RV32I decoder top level. A transferred word passes through the input register,
// then the result register, before it appears on the outputs.
// Throughput: one word per cycle while out_ready is high; the decode between the
// two registers is one opcode/funct3/funct7 lookup and an immediate mux.
// Reset (rst_n, asynchronous, active low) empties both stages; data is not reset.
// Depends on rvdec_pkg, rvdec_decode and rv32i_instruction_decoder_assert.svh.
`default_nettype none
`include "rv32i_instruction_decoder_assert.svh"

module rv32i_instruction_decoder
    import rvdec_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [WORD_W-1:0]  instr_word,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [6:0]              major_opcode,
    output logic [4:0]              dest_reg,
    output logic [2:0]              func3_field,
    output logic [4:0]              src1_reg,
    output logic [4:0]              src2_reg,
    output logic [6:0]              func7_field,
    output logic [WORD_W-1:0]       immediate,
    output logic [11:0]             csr_addr,
    output logic [WORD_W-1:0]       raw_word,
    output logic [5:0]              op_class
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [WORD_W-1:0] s1_word_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic [WORD_W-1:0] out_imm_reg;
    op_class_t         out_class_reg;

    logic              in_xfer;
    logic              out_xfer;
    logic              out_load;
    logic              out_has_imm;
    dec_result_t       dec;

    rvdec_decode u_decode (
        .instr_word (s1_word_reg),
        .result     (dec)
    );

    // The result register loads from a full input stage if empty or draining.
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_xfer)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_word_reg <= instr_word;
        if (out_load)
        begin
            out_word_reg  <= s1_word_reg;
            out_imm_reg   <= dec.immediate;
            out_class_reg <= dec.op_class;
        end
    end

    assign out_valid    = out_valid_reg;
    assign major_opcode = out_word_reg[6:0];
    assign dest_reg     = out_word_reg[11:7];
    assign func3_field  = out_word_reg[14:12];
    assign src1_reg     = out_word_reg[19:15];
    assign src2_reg     = out_word_reg[24:20];
    assign func7_field  = out_word_reg[31:25];
    assign immediate    = out_imm_reg;
    assign csr_addr     = out_word_reg[31:20];
    assign raw_word     = out_word_reg;
    assign op_class     = out_class_reg;

    assign out_has_imm = (major_opcode == OPC_LOAD)   || (major_opcode == OPC_OP_IMM) ||
                         (major_opcode == OPC_JALR)   || (major_opcode == OPC_SYSTEM) ||
                         (major_opcode == OPC_STORE)  || (major_opcode == OPC_BRANCH) ||
                         (major_opcode == OPC_JAL)    || (major_opcode == OPC_AUIPC)  ||
                         (major_opcode == OPC_LUI);

    // A word taken from the input stage lands in the result register unchanged.
    `RVDEC_ASSERT_NEXT(a_stage_move, clk, rst_n, out_load, out_valid_reg && (out_word_reg == $past(s1_word_reg)))
    // An accepted input word always occupies the input stage in the next cycle.
    `RVDEC_ASSERT_NEXT(a_in_capture, clk, rst_n, in_xfer, s1_valid_reg)
    // Opcodes without an immediate format give a zero immediate.
    `RVDEC_ASSERT_SAME(a_imm_zero, clk, rst_n, out_valid_reg && !out_has_imm, out_imm_reg == '0)
    // JAL is classified by opcode alone.
    `RVDEC_ASSERT_SAME(a_jal_class, clk, rst_n, out_valid_reg && (major_opcode == OPC_JAL), out_class_reg == CLS_JAL)

endmodule

`default_nettype wire
